/* src/tga_rle_pkg.sv */
package tga_rle_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned BPP_W    = 3;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 32;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BYTES_PER_PIXEL = 1'b0,
		REG_PIXEL_COUNT     = 1'b1
	} cfg_reg_t;

	localparam logic [BPP_W-1:0]   BPP_RESET    = 3'd4;
	localparam logic [BPP_W-1:0]   BPP_NARROW   = 3'd3;
	localparam logic [COUNT_W-1:0] COUNT_RESET  = 32'd1;
	localparam logic [BYTE_W-1:0]  RUN_BIAS     = 8'd127;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

/* src/tga_rle_byte_if.sv */
interface tga_rle_byte_if
	import tga_rle_pkg::*;
();
	logic  valid;
	logic  ready;
	byte_t stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

/* src/tga_rle_pixel_if.sv */
interface tga_rle_pixel_if
	import tga_rle_pkg::*;
();
	logic  valid;
	logic  ready;
	byte_t red;
	byte_t green;
	byte_t blue;
	byte_t alpha;
	byte_t repeat_res;
	logic  last_pixel;

	modport source (output valid, output red, output green, output blue, output alpha,
		output repeat_res, output last_pixel, input ready);
	modport sink (input valid, input red, input green, input blue, input alpha,
		input repeat_res, input last_pixel, output ready);
endinterface

/* src/tga_rle_cfg_if.sv */
interface tga_rle_cfg_if
	import tga_rle_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* src/tga_rle_pixel_decoder_unit.sv */
// TGA run-length pixel decoder. The stream channel carries the compressed pixel
// data of one image, one byte per request, starting right after the file header.
// The pixels channel returns one request per completed pixel in R, G, B, A order,
// with a repeat count (1 for a raw pixel, the clipped run length for a run) and a
// flag on the pixel that completes the image, after which the decoder rearms.
// The cfg channel writes bytes_per_pixel (index 0) and pixel_count (index 1);
// it is always ready and is meant to be used only while the decoder is idle.
// A byte accepted on the stream channel is registered in the byte register, then
// decoded into the result register, from which its pixel, if any, is offered.
// Throughput: one byte per cycle while the pixels channel does not stall, set by
// the single decode stage that sits between the byte register and the result register.
// When the receiver stalls, the result register holds its pixel and the byte
// register holds one more byte; the stream channel then drops ready.
// Reset (arst_n low) returns bytes_per_pixel to 4, pixel_count to 1, and the
// decoder to waiting for a packet header at the start of an image.
module tga_rle_pixel_decoder_unit
	import tga_rle_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	tga_rle_byte_if.sink    stream,
	tga_rle_pixel_if.source pixels,
	tga_rle_cfg_if.sink     cfg
);

	// Configuration registers.
	logic [BPP_W-1:0]   bpp_q;
	logic [COUNT_W-1:0] pixel_count_q;

	// Input stage.
	logic  byte_valid_s1;
	byte_t byte_s1;

	// Decoder state.
	logic         expect_header_q;
	logic         raw_packet_q;
	logic [7:0]   packet_left_q;
	logic [1:0]   byte_pos_q;
	byte_t        hold0_q, hold1_q, hold2_q;
	logic [COUNT_W-1:0] pixels_done_q;

	// Result register.
	logic  out_valid_q;
	byte_t red_q, green_q, blue_q, alpha_q, repeat_q;
	logic  last_q;

	logic out_free;
	logic advance;

	// Next-state and result logic.
	logic         narrow;
	logic         complete;
	logic         emit;
	logic         expect_header_d;
	logic         raw_packet_d;
	logic [7:0]   packet_left_d;
	logic [1:0]   byte_pos_d;
	logic [COUNT_W-1:0] pixels_done_d;
	logic [COUNT_W-1:0] total;
	logic [COUNT_W-1:0] need;
	logic [7:0]   rep_raw;
	logic [7:0]   rep;
	logic         last;
	byte_t        red_d, green_d, blue_d, alpha_d;

	assign cfg.ready = 1'b1;

	// A byte may be decoded whenever the result register is empty or being emptied.
	assign out_free     = !out_valid_q || pixels.ready;
	assign advance      = byte_valid_s1 && out_free;
	assign stream.ready = !byte_valid_s1 || out_free;

	assign narrow = (bpp_q == BPP_NARROW);
	// The pixel completes on the byte whose position reaches the pixel width.
	assign complete = narrow ? byte_pos_q[1] : (byte_pos_q == 2'd3);

	assign total = (pixel_count_q == '0) ? COUNT_RESET : pixel_count_q;
	assign need  = (pixels_done_q < total) ? (total - pixels_done_q) : COUNT_RESET;

	always_comb begin
		expect_header_d = expect_header_q;
		raw_packet_d    = raw_packet_q;
		packet_left_d   = packet_left_q;
		byte_pos_d      = byte_pos_q;
		pixels_done_d   = pixels_done_q;
		emit            = 1'b0;
		rep_raw         = raw_packet_q ? 8'd1 : packet_left_q;
		if (rep_raw == 8'd0) begin
			rep_raw = 8'd1;
		end
		rep  = ({{(COUNT_W-8){1'b0}}, rep_raw} > need) ? need[7:0] : rep_raw;
		last = ({{(COUNT_W-8){1'b0}}, rep} >= need);

		// Bytes arrive as B, G, R (, A).
		blue_d = hold0_q;
		if (byte_pos_q == 2'd3) begin
			green_d = hold1_q;
			red_d   = hold2_q;
			alpha_d = byte_s1;
		end else begin
			green_d = byte_pos_q[1] ? hold1_q : 8'd0;
			red_d   = byte_s1;
			alpha_d = 8'd0;
		end

		if (expect_header_q) begin
			// Header below 128 opens a raw packet, otherwise a run.
			raw_packet_d    = !byte_s1[7];
			packet_left_d   = byte_s1[7] ? (byte_s1 - RUN_BIAS) : (byte_s1 + 8'd1);
			expect_header_d = 1'b0;
			byte_pos_d      = 2'd0;
		end else if (!complete) begin
			byte_pos_d = byte_pos_q + 2'd1;
		end else begin
			emit       = 1'b1;
			byte_pos_d = 2'd0;
			if (raw_packet_q && packet_left_q > 8'd1) begin
				packet_left_d = packet_left_q - 8'd1;
			end else begin
				packet_left_d   = 8'd0;
				expect_header_d = 1'b1;
			end
			if (last) begin
				// Image done: rearm for the next one.
				pixels_done_d   = '0;
				expect_header_d = 1'b1;
				packet_left_d   = 8'd0;
				raw_packet_d    = 1'b0;
			end else begin
				pixels_done_d = pixels_done_q + {{(COUNT_W-8){1'b0}}, rep};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q           <= BPP_RESET;
			pixel_count_q   <= COUNT_RESET;
			byte_valid_s1   <= 1'b0;
			expect_header_q <= 1'b1;
			raw_packet_q    <= 1'b0;
			packet_left_q   <= 8'd0;
			byte_pos_q      <= 2'd0;
			pixels_done_q   <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_BYTES_PER_PIXEL: bpp_q <= cfg.data[BPP_W-1:0];
					REG_PIXEL_COUNT:     pixel_count_q <= cfg.data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (stream.ready) begin
				byte_valid_s1 <= stream.valid;
			end
			if (advance) begin
				expect_header_q <= expect_header_d;
				raw_packet_q    <= raw_packet_d;
				packet_left_q   <= packet_left_d;
				byte_pos_q      <= byte_pos_d;
				pixels_done_q   <= pixels_done_d;
			end
			if (out_free) begin
				out_valid_q <= advance && emit;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.stream_byte;
		end
		if (advance && !expect_header_q && !complete) begin
			case (byte_pos_q)
				2'd0:    hold0_q <= byte_s1;
				2'd1:    hold1_q <= byte_s1;
				2'd2:    hold2_q <= byte_s1;
				default: ;
			endcase
		end
		if (advance && emit) begin
			red_q    <= red_d;
			green_q  <= green_d;
			blue_q   <= blue_d;
			alpha_q  <= alpha_d;
			repeat_q <= rep;
			last_q   <= last;
		end
	end

	assign pixels.valid      = out_valid_q;
	assign pixels.red        = red_q;
	assign pixels.green      = green_q;
	assign pixels.blue       = blue_q;
	assign pixels.alpha      = alpha_q;
	assign pixels.repeat_res = repeat_q;
	assign pixels.last_pixel = last_q;

endmodule

/* tb/tga_rle_pixel_decoder_unit_tb.sv */
`timescale 1ns / 100ps

module tga_rle_pixel_decoder_unit_tb
	import tga_rle_pkg::*;
();

	// Packet header bytes at or above this value open a run, the rest a raw packet.
	localparam int unsigned RUN_FLAG     = 128;
	localparam int unsigned NARROW_WIDTH = 3;
	localparam int unsigned WIDE_WIDTH   = 4;

	// Cycles allowed after the last expected pixel before the decoder counts as
	// idle, covering the byte register and the result register.
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned TOTAL_BYTES   = 1350;
	localparam int unsigned QUIET_AFTER   = 1150;
	localparam int unsigned MAX_GEN_PIXELS = 60;
	localparam int unsigned LIMIT_CYCLES  = 500000;

	// One decoded pixel as it shows up on the pixels channel.
	typedef struct packed {
		byte_t red;
		byte_t green;
		byte_t blue;
		byte_t alpha;
		byte_t run_count;
		logic  last_pixel;
	} pixel_t;

	logic clk;
	logic arst_n;

	tga_rle_byte_if  stream_if ();
	tga_rle_pixel_if pixel_if ();
	tga_rle_cfg_if   cfg_if ();

	tga_rle_pixel_decoder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.pixels (pixel_if),
		.cfg    (cfg_if)
	);

	// Bytes waiting to be offered on the stream channel, and pixels that the
	// decoder owes us, oldest first.
	byte_t  pending_bytes[$];
	pixel_t expected_pixels[$];

	// Shadow of the decoder: register copies and packet/pixel tracking state.
	logic [BPP_W-1:0]   cfg_bpp;
	logic [COUNT_W-1:0] cfg_count;
	logic               want_header;
	logic               in_raw;
	int unsigned        packet_left;
	int unsigned        byte_pos;
	byte_t              color_hold [3];
	int unsigned        pixels_done;

	// Traffic shaping shared by the driver, the receiver and the sequence.
	logic        idling_on;
	logic        hold_off_req;
	logic        byte_taken;
	int unsigned send_gap;
	int unsigned stall_left;
	int unsigned hold_count;

	int unsigned bytes_queued;
	int unsigned bytes_accepted;
	int unsigned pixels_checked;
	int unsigned images_done;
	int unsigned reg_writes;
	int unsigned mismatches;
	int unsigned cycle_count;

	always #1 clk = ~clk;

	// Shadow decoder: consumes one accepted byte and, when that byte completes a
	// pixel, appends the pixel it must produce to expected_pixels.
	task automatic decode_byte(input byte_t b);
		int unsigned width;
		int unsigned total;
		int unsigned need;
		int unsigned rep;
		pixel_t      px;
		width = (cfg_bpp == BPP_NARROW) ? NARROW_WIDTH : WIDE_WIDTH;
		// A header byte only sets up the packet; it never yields a pixel.
		if (want_header) begin
			if (b < RUN_FLAG) begin
				in_raw = 1'b1;
				packet_left = b + 1;
			end else begin
				in_raw = 1'b0;
				packet_left = b - RUN_BIAS;
			end
			want_header = 1'b0;
			byte_pos = 0;
			return;
		end
		// Color bytes are gathered until the position reaches the pixel width.
		// The width is read fresh each byte, so a width change in the middle of a
		// pixel takes effect right away.
		if (byte_pos + 1 < width) begin
			color_hold[byte_pos] = b;
			byte_pos = byte_pos + 1;
			return;
		end
		// Stream order is B, G, R (, A). Alpha is the completing byte only when it
		// is the fourth one.
		if (byte_pos == WIDE_WIDTH - 1) begin
			px.blue  = color_hold[0];
			px.green = color_hold[1];
			px.red   = color_hold[2];
			px.alpha = b;
		end else begin
			px.blue  = color_hold[0];
			px.green = (byte_pos >= 2) ? color_hold[1] : 8'd0;
			px.red   = b;
			px.alpha = 8'd0;
		end
		byte_pos = 0;
		// An empty image decodes as one pixel, and a count lowered below what is
		// already done leaves exactly one pixel to go.
		total = (cfg_count == 0) ? 1 : cfg_count;
		need = (pixels_done < total) ? total - pixels_done : 1;
		rep = in_raw ? 1 : packet_left;
		if (rep == 0)
			rep = 1;
		// Runs that reach past the end of the image are clipped.
		if (rep > need)
			rep = need;
		px.last_pixel = (rep >= need);
		px.run_count = 8'(rep);
		if (in_raw && packet_left > 1) begin
			packet_left = packet_left - 1;
		end else begin
			packet_left = 0;
			want_header = 1'b1;
		end
		// The image-ending pixel rearms the decoder, even inside a raw packet:
		// whatever bytes that packet still had are then taken as headers.
		if (px.last_pixel) begin
			pixels_done = 0;
			want_header = 1'b1;
			packet_left = 0;
			in_raw = 1'b0;
		end else begin
			pixels_done = pixels_done + rep;
		end
		expected_pixels.push_back(px);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Monitor and scoreboard. Outputs are sampled at the rising edge, the same
	// edge at which the decoder takes requests, so every accepted request on any
	// channel is seen here exactly once. A pixel accepted at this edge always
	// belongs to a byte accepted at an earlier edge, so checking before decoding
	// keeps the expectation order right.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_if.valid && pixel_if.ready) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel request with nothing expected: r=%0d g=%0d b=%0d a=%0d",
						pixel_if.red, pixel_if.green, pixel_if.blue, pixel_if.alpha);
					mismatches++;
				end else begin
					pixel_t want;
					want = expected_pixels.pop_front();
					check_field("red", want.red, pixel_if.red);
					check_field("green", want.green, pixel_if.green);
					check_field("blue", want.blue, pixel_if.blue);
					check_field("alpha", want.alpha, pixel_if.alpha);
					check_field("repeat_res", want.run_count, pixel_if.repeat_res);
					check_field("last_pixel", want.last_pixel, pixel_if.last_pixel);
					pixels_checked++;
					if (want.last_pixel)
						images_done++;
				end
			end
			if (stream_if.valid && stream_if.ready) begin
				decode_byte(stream_if.stream_byte);
				bytes_accepted++;
				byte_taken = 1'b1;
			end
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.index)
					REG_BYTES_PER_PIXEL: cfg_bpp = cfg_if.data[BPP_W-1:0];
					REG_PIXEL_COUNT:     cfg_count = cfg_if.data;
					default: ;
				endcase
				reg_writes++;
			end
		end
	end

	// Byte driver. A new request is put up only once the previous one was taken,
	// so valid and the byte hold steady through backpressure. Now and then it
	// pauses for a random stretch, counted down in send_gap.
	always @(negedge clk) begin
		if (arst_n && (!stream_if.valid || byte_taken)) begin
			byte_taken = 1'b0;
			if (send_gap != 0) begin
				send_gap--;
				stream_if.valid <= 1'b0;
			end else if (idling_on && pending_bytes.size() != 0 &&
				$urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 18);
				stream_if.valid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				stream_if.valid <= 1'b1;
				stream_if.stream_byte <= pending_bytes.pop_front();
			end else begin
				stream_if.valid <= 1'b0;
			end
		end
	end

	// Pixel receiver. Besides short random stalls it can hold off for a long
	// stretch on request, counting the cycles here, so that the result register
	// and the byte register both fill and the stream channel has to drop ready.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off_req) begin
				pixel_if.ready <= 1'b0;
				hold_count++;
				if (hold_count == HOLD_CYCLES) begin
					hold_off_req = 1'b0;
					hold_count = 0;
				end
			end else if (stall_left != 0) begin
				pixel_if.ready <= 1'b0;
				stall_left--;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				pixel_if.ready <= 1'b0;
				stall_left = $urandom_range(0, 18);
			end else begin
				pixel_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog for a decoder that hangs or drops pixels.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timed out with %0d pixels still expected", expected_pixels.size());
			$display("[tga_rle_pixel_decoder_unit] ERROR");
			$finish;
		end
	end

	task automatic queue_byte(input byte_t b);
		pending_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic queue_pixel(input int unsigned width);
		repeat (width)
			queue_byte(byte_t'($urandom_range(0, 255)));
	endtask

	// Builds a well-formed image of run and raw packets covering at least the
	// given number of pixels. The last packet may overshoot, which exercises run
	// clipping and raw packets that run past the image end. Now and then a short
	// burst of random bytes breaks the packet framing.
	task automatic queue_image(input int unsigned pixels, input int unsigned width);
		int unsigned covered;
		int unsigned kind;
		int unsigned len;
		covered = 0;
		while (covered < pixels) begin
			kind = $urandom_range(0, 15);
			if (kind == 0) begin
				repeat ($urandom_range(1, 6))
					queue_byte(byte_t'($urandom));
			end else if (kind < 8) begin
				len = (kind == 1) ? $urandom_range(1, 128) : $urandom_range(1, 8);
				queue_byte(byte_t'(len + RUN_BIAS));
				queue_pixel(width);
				covered += len;
			end else begin
				len = ($urandom_range(0, 63) == 0) ? $urandom_range(1, 128) :
					$urandom_range(1, 6);
				queue_byte(byte_t'(len - 1));
				repeat (len)
					queue_pixel(width);
				covered += len;
			end
		end
	endtask

	// Register write through the cfg channel; the shadow copy is updated by the
	// monitor when the request is taken.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Waits until every byte has been taken and every expected pixel has come
	// back, then lets the pipeline settle, since the last bytes may be headers or
	// partial pixels still in flight.
	task automatic wait_idle();
		while (pending_bytes.size() != 0 || stream_if.valid || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	initial begin
		int unsigned      round;
		int unsigned      r;
		int unsigned      gen_width;
		int unsigned      gen_pixels;
		logic [BPP_W-1:0] new_bpp;
		logic [31:0]      new_count;

		clk = 1'b0;
		arst_n = 1'b0;
		stream_if.valid = 1'b0;
		stream_if.stream_byte = '0;
		pixel_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_BYTES_PER_PIXEL;
		cfg_if.data = '0;

		cfg_bpp = BPP_RESET;
		cfg_count = COUNT_RESET;
		want_header = 1'b1;
		in_raw = 1'b0;
		packet_left = 0;
		byte_pos = 0;
		color_hold[0] = '0;
		color_hold[1] = '0;
		color_hold[2] = '0;
		pixels_done = 0;

		idling_on = 1'b1;
		hold_off_req = 1'b0;
		byte_taken = 1'b0;
		send_gap = 0;
		stall_left = 0;
		hold_count = 0;
		bytes_queued = 0;
		bytes_accepted = 0;
		pixels_checked = 0;
		images_done = 0;
		reg_writes = 0;
		mismatches = 0;
		cycle_count = 0;

		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings (four bytes per pixel, one pixel): a one-pixel run whose
		// color bytes swing between all zeros and all ones.
		queue_byte(8'h80);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		wait_idle();

		// Three-byte pixels and an empty image, which decodes as one pixel: the
		// longest possible run is clipped to a single pixel.
		write_reg(REG_BYTES_PER_PIXEL, BPP_NARROW);
		write_reg(REG_PIXEL_COUNT, 32'd0);
		queue_byte(8'hFF);
		queue_byte(8'hFF);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		wait_idle();

		// Longest raw packet on a two-pixel image: after the second pixel the rest
		// of the packet is read as fresh packet headers, here a run of three that
		// gets clipped to the whole new image.
		write_reg(REG_PIXEL_COUNT, 32'd2);
		queue_byte(8'h7F);
		repeat (2)
			queue_pixel(NARROW_WIDTH);
		queue_byte(8'h82);
		queue_pixel(NARROW_WIDTH);
		wait_idle();

		// An odd width code acting as four bytes, on the largest image. Then, in
		// the middle of a pixel, the width drops to three and the count drops
		// below what is already done: the next byte completes both the pixel and
		// the image with a repeat of one.
		write_reg(REG_BYTES_PER_PIXEL, 3'd7);
		write_reg(REG_PIXEL_COUNT, 32'hFFFF_FFFF);
		queue_byte(8'h81);
		queue_pixel(WIDE_WIDTH);
		queue_byte(8'h00);
		queue_byte(8'h5A);
		queue_byte(8'hA5);
		wait_idle();
		write_reg(REG_BYTES_PER_PIXEL, BPP_NARROW);
		write_reg(REG_PIXEL_COUNT, 32'd1);
		queue_byte(8'h3C);
		wait_idle();

		// Random images under changing settings. The first round stalls the
		// receiver for a long stretch while a large image is offered; every round
		// starts once all owed pixels are back, which is where the registers
		// change. The last stretch runs with no idling at all.
		gen_width = NARROW_WIDTH;
		round = 0;
		while (bytes_queued < TOTAL_BYTES) begin
			wait_idle();
			idling_on = (bytes_queued < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
			if (round == 0) begin
				new_bpp = BPP_RESET;
				new_count = 32'd40;
				write_reg(REG_BYTES_PER_PIXEL, new_bpp);
				write_reg(REG_PIXEL_COUNT, new_count);
			end else begin
				if ($urandom_range(0, 1) == 0) begin
					r = $urandom_range(0, 9);
					new_bpp = (r < 4) ? BPP_NARROW : (r < 8) ? BPP_RESET :
						BPP_W'($urandom_range(0, 7));
					write_reg(REG_BYTES_PER_PIXEL, new_bpp);
				end
				if ($urandom_range(0, 3) != 0) begin
					r = $urandom_range(0, 19);
					new_count = (r < 14) ? 32'($urandom_range(1, 12)) :
						(r < 17) ? 32'($urandom_range(13, 300)) :
						(r == 17) ? 32'd0 :
						(r == 18) ? 32'hFFFF_FFFF : 32'($urandom);
					write_reg(REG_PIXEL_COUNT, new_count);
				end
			end
			gen_width = (cfg_bpp == BPP_NARROW) ? NARROW_WIDTH : WIDE_WIDTH;
			gen_pixels = (cfg_count == 0) ? 1 :
				(cfg_count > MAX_GEN_PIXELS) ? MAX_GEN_PIXELS : cfg_count;
			repeat ($urandom_range(1, 3))
				queue_image(gen_pixels, gen_width);
			if (round == 0)
				hold_off_req = 1'b1;
			round++;
		end
		wait_idle();

		$display("Checked %0d pixels from %0d stream bytes: %0d images, %0d register writes.",
			pixels_checked, bytes_accepted, images_done, reg_writes);
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("[tga_rle_pixel_decoder_unit] OK");
		end else begin
			$display("[tga_rle_pixel_decoder_unit] ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/tga_rle_pkg.sv
src/tga_rle_byte_if.sv
src/tga_rle_pixel_if.sv
src/tga_rle_cfg_if.sv
src/tga_rle_pixel_decoder_unit.sv
tb/tga_rle_pixel_decoder_unit_tb.sv
